// ----- rtl/semaphore_unit_round_robin_wake_defines.svh -----
// Assertion macros for the semaphore bank with round-robin wakeup.
`ifndef SEMAPHORE_UNIT_ROUND_ROBIN_WAKE_DEFINES_SVH
`define SEMAPHORE_UNIT_ROUND_ROBIN_WAKE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SURRW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SURRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/surrw_pkg.sv -----
// Shared types, constants and the bit_pos helper function of the semaphore bank.
package surrw_pkg;

    localparam int NUM_SEMAPHORES = 8;
    localparam int NUM_PROCESSES  = 8;

    localparam int OPCODE_W = 2;
    localparam int SEM_W    = 3;
    localparam int COUNT_W  = 8;
    localparam int PID_W    = 3;
    localparam int MASK_W   = 8;
    localparam int CMP_W    = 8;
    localparam int SEM_AW   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [OPCODE_W-1:0] OP_INIT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POST = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WAIT = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    function automatic logic [PID_W-1:0] bit_pos(input logic [MASK_W-1:0] v);
        logic [PID_W-1:0] p;
        logic             hit;
        p   = '0;
        hit = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (!hit && v[i])
            begin
                p   = PID_W'(i);
                hit = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

// ----- rtl/surrw_ctrl.sv -----
// Controller: capture a beat, run one table update, hold the result until taken.
module surrw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output surrw_pkg::cmd_t    cmd
);

    surrw_pkg::state_t state_reg;
    surrw_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            surrw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = surrw_pkg::ST_EXEC;
                end
            end
            surrw_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = surrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = surrw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            surrw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            surrw_pkg::ST_EXEC:
            begin
                cmd.exec = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= surrw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/surrw_dp.sv -----
// Datapath: semaphore table, read-modify-write of one entry, result register.
module surrw_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  surrw_pkg::cmd_t                 cmd,
    input  logic [surrw_pkg::S_TDATA_W-1:0] in_data,
    output logic [surrw_pkg::M_TDATA_W-1:0] out_data
);

    localparam int NS = surrw_pkg::NUM_SEMAPHORES;
    localparam int NP = surrw_pkg::NUM_PROCESSES;
    localparam int MW = surrw_pkg::MASK_W;
    localparam int PW = surrw_pkg::PID_W;
    localparam int CW = surrw_pkg::COUNT_W;

    logic [surrw_pkg::OPCODE_W-1:0] op_reg;
    logic [surrw_pkg::SEM_W-1:0]    idx_reg;
    logic signed [CW-1:0]           ival_reg;
    logic [PW-1:0]                  pid_reg;

    logic signed [CW-1:0] cnt_reg     [NS];
    logic [MW-1:0]        waiters_reg [NS];
    logic [MW-1:0]        lw_reg      [NS];
    logic [MW-1:0]        global_reg;

    logic signed [CW-1:0] cnt_next;
    logic [MW-1:0]        waiters_next;
    logic [MW-1:0]        lw_next;
    logic [MW-1:0]        global_next;

    logic [surrw_pkg::SEM_AW-1:0] addr;
    logic                         bad;
    logic signed [CW-1:0]         cnt_cur;
    logic [MW-1:0]                waiters_cur;
    logic [PW-1:0]                start;
    logic                         found;
    logic [PW-1:0]                found_pid;
    logic [PW:0]                  pos;
    logic [MW-1:0]                pid_bit;
    logic [MW-1:0]                wake_bit;
    logic                         pid_ok;

    logic          granted;
    logic          blocked;
    logic          wvalid;
    logic [PW-1:0] wproc;

    logic          res_bad_reg;
    logic          res_granted_reg;
    logic          res_blocked_reg;
    logic          res_wvalid_reg;
    logic [PW-1:0] res_wproc_reg;
    logic [CW-1:0] res_count_reg;
    logic [MW-1:0] res_mask_reg;

    assign addr        = surrw_pkg::SEM_AW'(idx_reg);
    assign bad         = surrw_pkg::CMP_W'(idx_reg) >= surrw_pkg::CMP_W'(NS);
    assign cnt_cur     = cnt_reg[addr];
    assign waiters_cur = waiters_reg[addr];
    assign start       = surrw_pkg::bit_pos(lw_reg[addr]);
    assign pid_ok      = surrw_pkg::CMP_W'(pid_reg) < surrw_pkg::CMP_W'(NP);
    assign pid_bit     = MW'(1) << pid_reg;
    assign wake_bit    = MW'(1) << found_pid;

    always_comb
    begin
        found     = 1'b0;
        found_pid = '0;
        pos       = '0;
        for (int k = 1; k <= NP; k++)
        begin
            pos = (PW+1)'(start) + (PW+1)'(k);
            if (pos >= (PW+1)'(NP))
            begin
                pos = pos - (PW+1)'(NP);
            end
            if (!found && waiters_cur[pos[PW-1:0]])
            begin
                found     = 1'b1;
                found_pid = pos[PW-1:0];
            end
        end
    end

    always_comb
    begin
        cnt_next     = cnt_cur;
        waiters_next = waiters_cur;
        lw_next      = lw_reg[addr];
        global_next  = global_reg;
        granted      = 1'b0;
        blocked      = 1'b0;
        wvalid       = 1'b0;
        wproc        = '0;
        case (op_reg)
            surrw_pkg::OP_INIT:
            begin
                cnt_next     = ival_reg;
                waiters_next = '0;
                lw_next      = MW'(1);
            end
            surrw_pkg::OP_POST:
            begin
                if (waiters_cur == '0)
                begin
                    cnt_next = cnt_cur + CW'(1);
                end
                else
                begin
                    waiters_next = waiters_cur & ~wake_bit;
                    global_next  = global_reg & ~wake_bit;
                    lw_next      = wake_bit;
                    wvalid       = found;
                    wproc        = found_pid;
                end
            end
            surrw_pkg::OP_WAIT:
            begin
                if (cnt_cur != '0)
                begin
                    cnt_next = cnt_cur - CW'(1);
                    granted  = 1'b1;
                end
                else if (pid_ok)
                begin
                    waiters_next = waiters_cur | pid_bit;
                    global_next  = global_reg | pid_bit;
                    blocked      = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_cur;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_data[1:0];
            idx_reg  <= in_data[4:2];
            ival_reg <= in_data[12:5];
            pid_reg  <= in_data[15:13];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                cnt_reg[i]     <= '0;
                waiters_reg[i] <= '0;
                lw_reg[i]      <= MW'(1);
            end
            global_reg <= '0;
        end
        else if (cmd.exec && !bad)
        begin
            cnt_reg[addr]     <= cnt_next;
            waiters_reg[addr] <= waiters_next;
            lw_reg[addr]      <= lw_next;
            global_reg        <= global_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (bad)
            begin
                res_bad_reg     <= 1'b1;
                res_granted_reg <= 1'b0;
                res_blocked_reg <= 1'b0;
                res_wvalid_reg  <= 1'b0;
                res_wproc_reg   <= '0;
                res_count_reg   <= '0;
                res_mask_reg    <= global_reg;
            end
            else
            begin
                res_bad_reg     <= 1'b0;
                res_granted_reg <= granted;
                res_blocked_reg <= blocked;
                res_wvalid_reg  <= wvalid;
                res_wproc_reg   <= wproc;
                res_count_reg   <= cnt_next;
                res_mask_reg    <= global_next;
            end
        end
    end

    assign out_data = {1'b0, res_mask_reg, res_count_reg, res_wproc_reg, res_wvalid_reg,
                       res_blocked_reg, res_granted_reg, res_bad_reg};

endmodule

// ----- rtl/semaphore_unit_round_robin_wake.sv -----
// Semaphore bank with round-robin wakeup: one input beat in, one result beat out.
// Each operation captures the input beat in ST_IDLE, then in ST_EXEC reads, updates and
// writes back the addressed semaphore entry into the result register. A new beat is
// taken as soon as that update is done, while the previous result may still wait on the
// output; the update cycle holds only while an untaken result occupies the result
// register. The table comes out of reset already cleared, so beats are taken at once.
module semaphore_unit_round_robin_wake (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[1:0], sem_index[4:2], init_value[12:5], process_id[15:13]
    input  logic [surrw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // bad_index[0], granted[1], blocked[2], woken_valid[3], woken_process[6:4],
    // count_after[14:7], waiting_mask[22:15], zero[23]
    output logic [surrw_pkg::M_TDATA_W-1:0] m_tdata
);

`include "semaphore_unit_round_robin_wake_defines.svh"

    surrw_pkg::cmd_t cmd;

    surrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    surrw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

    `SURRW_ASSERT_SAME(a_one_outcome, m_tvalid, $onehot0({m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3]}), "more than one outcome flag in result beat")
    `SURRW_ASSERT_SAME(a_wproc_zero, m_tvalid && !m_tdata[3], m_tdata[6:4] == 3'd0, "woken process set without wakeup")
    `SURRW_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready && cmd.exec == (!m_tvalid || m_tready), "beat taken while an update is pending")
    `SURRW_ASSERT_NEXT(a_result_follows, cmd.exec, m_tvalid, "update without result beat")

endmodule
